>>> sv/text_loaded_waveform_player_macros.svh
// assertion macros used by the port-level checker
`ifndef TEXT_LOADED_WAVEFORM_PLAYER_MACROS_SVH
`define TEXT_LOADED_WAVEFORM_PLAYER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TLWP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TLWP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tlwp_pkg.sv
// types and constants of the text loaded waveform player
`default_nettype none
package tlwp_pkg;

  localparam int unsigned SAMPLES_DEF     = 105;
  localparam int unsigned DIGIT_SLOTS_DEF = 16;

  localparam logic [1:0] OP_TEXT    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_RECEIVING = 3'd1;
  localparam logic [2:0] MODE_LOADED    = 3'd2;
  localparam logic [2:0] MODE_PLAYING   = 3'd3;
  localparam logic [2:0] MODE_PAUSED    = 3'd4;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  localparam int unsigned SAMPLE_W = 12;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] text_byte;
    logic       long_press;
  } in_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic                dac_valid;
    logic [SAMPLE_W-1:0] dac_sample;
    logic                sample_stored;
    logic [6:0]          stored_slot;
    logic [31:0]         stored_number;
    logic                table_loaded;
  } out_t;

endpackage
`default_nettype wire

>>> sv/text_loaded_waveform_player.sv
// Text loaded waveform player. Takes one item per clock on the input channel and
// returns exactly one result per item, registered in the cycle after acceptance; a
// sustained rate of one item per cycle holds as long as the output is not stalled,
// and the input stalls only while a finished result waits under output stall.
// Decimal text bytes build SAMPLES 12-bit values, written by commas into the idle
// half of a 2*SAMPLES entry single-port-write memory; the halves swap when the last
// slot is filled. Sample ticks while playing read the active half through the
// memory's registered read port. The memory is never cleared and needs no start-up
// pass; playback is reachable only after a full load.
`default_nettype none
module text_loaded_waveform_player #(
  parameter int unsigned SAMPLES     = tlwp_pkg::SAMPLES_DEF,
  parameter int unsigned DIGIT_SLOTS = tlwp_pkg::DIGIT_SLOTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire tlwp_pkg::in_t  in_beat_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output tlwp_pkg::out_t      out_beat_o
);

  import tlwp_pkg::*;

  localparam int unsigned SLOT_W  = $clog2(SAMPLES);
  localparam int unsigned DIGIT_W = $clog2(DIGIT_SLOTS);
  localparam int unsigned DEPTH   = 2 * SAMPLES;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE      = MODE_IDLE,
    ST_RECEIVING = MODE_RECEIVING,
    ST_LOADED    = MODE_LOADED,
    ST_PLAYING   = MODE_PLAYING,
    ST_PAUSED    = MODE_PAUSED
  } mode_e;

  mode_e               mode_q, mode_d;
  logic [DIGIT_W-1:0]  digit_count_q, digit_count_d;
  logic [31:0]         accum_q, accum_d;
  logic [SLOT_W-1:0]   write_slot_q, write_slot_d;
  logic [SLOT_W-1:0]   play_slot_q, play_slot_d;
  logic                bank_q, bank_d;
  logic                out_valid_q, out_valid_d;
  out_t                res_q, res_d;

  logic                accept;
  logic                is_digit;
  logic [31:0]         accum_x10;
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [SAMPLE_W-1:0] rd_data;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_digit   = (in_beat_i.text_byte >= CHAR_ZERO) && (in_beat_i.text_byte <= CHAR_NINE);
  assign accum_x10  = {accum_q[28:0], 3'b000} + {accum_q[30:0], 1'b0};

  always_comb begin
    mode_d        = mode_q;
    digit_count_d = digit_count_q;
    accum_d       = accum_q;
    write_slot_d  = write_slot_q;
    play_slot_d   = play_slot_q;
    bank_d        = bank_q;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    // text is written into the idle bank, ticks read the active one
    wr_addr       = bank_q ? ADDR_W'(write_slot_q) : ADDR_W'(SAMPLES) + ADDR_W'(write_slot_q);
    rd_addr       = bank_q ? ADDR_W'(SAMPLES) + ADDR_W'(play_slot_q) : ADDR_W'(play_slot_q);
    res_d         = '0;

    case (in_beat_i.op)
      OP_TEXT: begin
        if (mode_q == ST_RECEIVING || mode_q == ST_LOADED) begin
          if (is_digit) begin
            if (digit_count_q < DIGIT_W'(DIGIT_SLOTS - 1)) begin
              accum_d       = accum_x10 + 32'(in_beat_i.text_byte - CHAR_ZERO);
              digit_count_d = digit_count_q + DIGIT_W'(1);
            end
          end else if (in_beat_i.text_byte == CHAR_COMMA) begin
            wr_en               = 1'b1;
            res_d.sample_stored = 1'b1;
            res_d.stored_slot   = 7'(write_slot_q);
            res_d.stored_number = accum_q;
            accum_d             = '0;
            digit_count_d       = '0;
            if (write_slot_q == SLOT_W'(SAMPLES - 1)) begin
              write_slot_d       = '0;
              bank_d             = ~bank_q;
              mode_d             = ST_LOADED;
              res_d.table_loaded = 1'b1;
            end else begin
              write_slot_d = write_slot_q + SLOT_W'(1);
            end
          end
        end
      end
      OP_PRESS: begin
        case (mode_q)
          ST_IDLE: mode_d = ST_RECEIVING;
          ST_LOADED, ST_PAUSED: begin
            mode_d       = ST_PLAYING;
            write_slot_d = '0;
            play_slot_d  = '0;
          end
          ST_PLAYING: mode_d = ST_PAUSED;
          default: mode_d = mode_q;
        endcase
      end
      OP_RELEASE: begin
        if (in_beat_i.long_press && (mode_q == ST_PLAYING || mode_q == ST_PAUSED)) begin
          mode_d = ST_IDLE;
        end
      end
      OP_TICK: begin
        if (mode_q == ST_PLAYING) begin
          rd_en           = 1'b1;
          res_d.dac_valid = 1'b1;
          play_slot_d     = (play_slot_q == SLOT_W'(SAMPLES - 1)) ? '0
                                                                  : play_slot_q + SLOT_W'(1);
        end
      end
      default: ;
    endcase

    res_d.mode = 3'(mode_d);
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ST_IDLE;
      digit_count_q <= '0;
      accum_q       <= '0;
      write_slot_q  <= '0;
      play_slot_q   <= '0;
      bank_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        mode_q        <= mode_d;
        digit_count_q <= digit_count_d;
        accum_q       <= accum_d;
        write_slot_q  <= write_slot_d;
        play_slot_q   <= play_slot_d;
        bank_q        <= bank_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  tlwp_bank_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_W)
  ) u_bank_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en & accept),
    .wr_addr_i (wr_addr),
    .wr_data_i (accum_q[SAMPLE_W-1:0]),
    .rd_en_i   (rd_en & accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // sample comes straight from the memory read register
  always_comb begin
    out_beat_o            = res_q;
    out_beat_o.dac_sample = res_q.dac_valid ? rd_data : '0;
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> sv/tlwp_bank_ram.sv
// double-bank sample memory: one write port, one registered read port
`default_nettype none
module tlwp_bank_ram #(
  parameter int unsigned DEPTH  = 210,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 12
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read so a stalled beat keeps its sample
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

>>> sv/tlwp_checker.sv
// port-level checks of the waveform player and their bind
`default_nettype none
`include "text_loaded_waveform_player_macros.svh"
module tlwp_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire tlwp_pkg::out_t out_beat_o
);

  import tlwp_pkg::*;

  // every accepted beat yields a result beat on the next cycle
  `TLWP_ASSERT_NEXT(a_accept_gives_result, in_valid_i && !in_stall_o, out_valid_o, "accepted beat gave no result")

  // samples only leave while playing
  `TLWP_ASSERT_NOW(a_dac_only_playing, out_valid_o && out_beat_o.dac_valid, out_beat_o.mode == MODE_PLAYING, "sample outside playing")

  // a completed table always comes from a stored comma and lands in loaded
  `TLWP_ASSERT_NOW(a_loaded_on_store, out_valid_o && out_beat_o.table_loaded, out_beat_o.sample_stored && out_beat_o.mode == MODE_LOADED, "table swap without store")

  // a sample and a store never share a beat
  `TLWP_ASSERT_NOW(a_store_excl_dac, out_valid_o && out_beat_o.sample_stored, !out_beat_o.dac_valid, "store and sample in one beat")

  `TLWP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat_o), "stalled result changed")

endmodule

bind text_loaded_waveform_player tlwp_checker u_tlwp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
`default_nettype wire
